// File: sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the SBUS frame decoder
// Frame layout, channel packing and the structs passed between units.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int DATA_BYTES  = FRAME_BYTES - 3;    // bytes 1..22 carry channels
  localparam int DATA_W      = DATA_BYTES * 8;
  localparam int FLAG_POS    = FRAME_BYTES - 2;
  localparam int FOOTER_POS  = FRAME_BYTES - 1;
  localparam int POS_W       = 5;
  localparam int CHANNELS    = 16;
  localparam int CHAN_W      = 11;
  localparam int IDX_W       = 4;
  localparam int FLAG_W      = 4;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] FOOTER_BYTE = 8'h00;

  // One good frame: channel bits LSB-first from byte 1, low flag nibble of byte 23
  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [DATA_W-1:0] data;
  } frame_t;

  typedef struct packed {
    logic [IDX_W-1:0]  channel_index;
    logic [CHAN_W-1:0] channel_value;
    logic              digital_ch17;
    logic              digital_ch18;
    logic              frame_lost;
    logic              failsafe_active;
    logic              last_of_frame;
  } result_t;

endpackage

`default_nettype wire

// File: sv/sfd_ifs.sv
// ----------------------------------------------------------------------------
// sfd_ifs: stream interfaces of the SBUS frame decoder
// Byte request channel in, channel result channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_chan_if;
  import sfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  channel_index;
  logic [CHAN_W-1:0] channel_value;
  logic              digital_ch17;
  logic              digital_ch18;
  logic              frame_lost;
  logic              failsafe_active;
  logic              last_of_frame;

  modport source (output valid, output channel_index, output channel_value,
                  output digital_ch17, output digital_ch18, output frame_lost,
                  output failsafe_active, output last_of_frame, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input digital_ch17, input digital_ch18, input frame_lost,
                  input failsafe_active, input last_of_frame, output ready);
endinterface

`default_nettype wire

// File: sv/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front: byte framer
// Hunts for a header after a footer, collects the frame, pushes good frames.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  output logic            in_ready,
  input  logic            q_full,
  output logic            push,
  output sfd_pkg::frame_t push_frame
);
  import sfd_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [7:0]        last_byte_r;
  logic [DATA_W-1:0] data_r;
  logic [FLAG_W-1:0] flags_r;
  logic              take;
  logic              at_footer;

  assign at_footer = (pos_r == POS_W'(FOOTER_POS));
  // Hold the footer byte whenever the queue is full, whether the frame is good or not
  assign in_ready  = !(at_footer && q_full);
  assign take      = in_valid && in_ready;
  assign push      = take && at_footer && (in_byte == FOOTER_BYTE);
  assign push_frame.data  = data_r;
  assign push_frame.flags = flags_r;

  always_comb begin
    pos_nxt = pos_r;
    priority if (pos_r == '0) begin
      if (in_byte == HEADER_BYTE && last_byte_r == FOOTER_BYTE) begin
        pos_nxt = POS_W'(1);
      end
    end else if (at_footer) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      last_byte_r <= FOOTER_BYTE;
    end else if (take) begin
      pos_r       <= pos_nxt;
      last_byte_r <= in_byte;
    end
  end

  // Shift data bytes in from the top so byte 1 ends up in the low bits
  always_ff @(posedge clk) begin
    if (take && pos_r != '0 && pos_r < POS_W'(FLAG_POS)) begin
      data_r <= {in_byte, data_r[DATA_W-1:8]};
    end
    if (take && pos_r == POS_W'(FLAG_POS)) begin
      flags_r <= in_byte[FLAG_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: sv/sfd_queue.sv
// ----------------------------------------------------------------------------
// sfd_queue: frame queue
// Small FIFO of decoded frames between framer and channel unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sfd_pkg::frame_t push_frame,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output sfd_pkg::frame_t head
);
  import sfd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_frame;
  end

endmodule

`default_nettype wire

// File: sv/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back: channel unpacker
// Emits the sixteen 11-bit channels of a frame, one per cycle while out_ready allows, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  sfd_pkg::frame_t  q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output sfd_pkg::result_t out_result
);
  import sfd_pkg::*;

  logic              active_r;
  logic [IDX_W-1:0]  ch_r;
  logic [DATA_W-1:0] shreg_r;
  logic [FLAG_W-1:0] flags_r;
  logic              out_valid_r;
  result_t           out_r;
  logic              adv;
  logic              last_ch;

  assign last_ch    = (ch_r == IDX_W'(CHANNELS - 1));
  assign adv        = active_r && (!out_valid_r || out_ready);
  assign pop        = q_not_empty && (!active_r || (adv && last_ch));
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ch_r        <= '0;
    end else begin
      if (adv)            out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (pop) begin
        active_r <= 1'b1;
        ch_r     <= '0;
      end else if (adv) begin
        if (last_ch) active_r <= 1'b0;
        ch_r <= ch_r + 1'b1;
      end
    end
  end

  // Advance the channel window by one field per result
  always_ff @(posedge clk) begin
    if (pop) begin
      shreg_r <= q_head.data;
      flags_r <= q_head.flags;
    end else if (adv) begin
      shreg_r <= shreg_r >> CHAN_W;
    end
    if (adv) begin
      out_r.channel_index   <= ch_r;
      out_r.channel_value   <= shreg_r[CHAN_W-1:0];
      out_r.digital_ch17    <= flags_r[0];
      out_r.digital_ch18    <= flags_r[1];
      out_r.frame_lost      <= flags_r[2];
      out_r.failsafe_active <= flags_r[3];
      out_r.last_of_frame   <= last_ch;
    end
  end

endmodule

`default_nettype wire

// File: sv/sbus_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_top: SBUS receive frame decoder, 16 channels of 11 bits
// Output: after a good footer the unpacker emits the frame's sixteen channel
//   results, one result per cycle while the sink is ready.
// Input: one byte request per cycle; the footer stalls only while the
//   frame queue is full.
// Reset: rst_n synchronous, active low; hunts for a header, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module sbus_frame_decoder_top #(
  parameter int QUEUE_DEPTH = 2     // frames buffered between framer and unpacker, 2..8
) (
  input  logic       clk,
  input  logic       rst_n,
  sfd_byte_if.sink   in_if,
  sfd_chan_if.source out_if
);
  import sfd_pkg::*;

  logic    q_full;
  logic    q_not_empty;
  logic    push;
  logic    pop;
  frame_t  push_frame;
  frame_t  q_head;
  result_t result;

  // Framer: classify each byte request by frame position, push good frames
  sfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_byte    (in_if.rx_byte),
    .in_ready   (in_if.ready),
    .q_full     (q_full),
    .push       (push),
    .push_frame (push_frame)
  );

  // Queue: lets the framer keep taking bytes while the unpacker drains
  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Unpacker: one channel per cycle into the output register while the sink is ready
  sfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_result  (result)
  );

  // Spread the result struct onto the channel payload
  assign out_if.channel_index   = result.channel_index;
  assign out_if.channel_value   = result.channel_value;
  assign out_if.digital_ch17    = result.digital_ch17;
  assign out_if.digital_ch18    = result.digital_ch18;
  assign out_if.frame_lost      = result.frame_lost;
  assign out_if.failsafe_active = result.failsafe_active;
  assign out_if.last_of_frame   = result.last_of_frame;

endmodule

`default_nettype wire

// File: verif/sbus_frame_decoder_top_test.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_top_test: self-checking bench for the SBUS frame decoder
// Streams byte requests into the decoder under random valid and ready gaps,
// predicts the sixteen channel results of every good frame and compares each
// result field by field, in order, as it leaves the block.
// ----------------------------------------------------------------------------
`default_nettype none

module sbus_frame_decoder_top_test;
  import sfd_pkg::*;

  logic clk;
  logic rst_n;

  sfd_byte_if byte_req ();
  sfd_chan_if chan_res ();

  sbus_frame_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (byte_req),
    .out_if (chan_res)
  );

  // Free-running clock, period 8
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Frame predictor state: mirrors the decoder's hunt/collect behavior
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] frame_pos;                 // 0 while hunting for a header
  logic [7:0]       prev_byte;                 // every accepted byte lands here
  logic [7:0]       frame_buf [FRAME_BYTES];

  result_t expected_channels [$];              // channel results still owed

  // Idle controls: clear to run a side with no gaps at all
  bit src_idle;
  bit snk_idle;

  int error_count;
  int bytes_sent;
  int results_checked;
  int frames_good;
  int frames_dropped;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  task automatic clear_frame_state();
    frame_pos = '0;
    prev_byte = FOOTER_BYTE;   // a header as the very first byte opens a frame
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;
  endtask

  // Queue the sixteen channel results of the frame held in frame_buf
  task automatic unpack_frame();
    logic [DATA_W-1:0] chan_bits;
    result_t           r;
    for (int i = 0; i < DATA_BYTES; i++) chan_bits[i*8 +: 8] = frame_buf[i+1];
    for (int k = 0; k < CHANNELS; k++) begin
      r.channel_index   = IDX_W'(k);
      r.channel_value   = chan_bits[k*CHAN_W +: CHAN_W];
      // only the low nibble of the flag byte matters
      r.digital_ch17    = frame_buf[FLAG_POS][0];
      r.digital_ch18    = frame_buf[FLAG_POS][1];
      r.frame_lost      = frame_buf[FLAG_POS][2];
      r.failsafe_active = frame_buf[FLAG_POS][3];
      r.last_of_frame   = (k == CHANNELS - 1);
      expected_channels.push_back(r);
    end
  endtask

  // Advance the predictor by one accepted byte request
  task automatic predict_byte(input logic [7:0] b);
    bit frame_done;
    frame_done = 1'b0;
    if (frame_pos == 0) begin
      // hunting: open a frame only on a header right after a zero byte
      if (b == HEADER_BYTE && prev_byte == FOOTER_BYTE) begin
        frame_buf[0] = b;
        frame_pos    = 1;
      end
    end else begin
      // collecting: a header here is plain data, no resync
      frame_buf[frame_pos] = b;
      if (frame_pos < FOOTER_POS) begin
        frame_pos++;
      end else begin
        frame_pos = 0;
        if (b == FOOTER_BYTE) begin
          frame_done = 1'b1;
          frames_good++;
        end else begin
          frames_dropped++;   // bad footer: drop without output
        end
      end
    end
    // track every byte, the footer of a good frame included
    prev_byte = b;
    if (frame_done) unpack_frame();
  endtask

  // --------------------------------------------------------------------------
  // Byte request driver
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      byte_req.valid <= 1'b0;
      @(posedge clk);
    end
    byte_req.valid   <= 1'b1;
    byte_req.rx_byte <= b;
    // hold the request until the decoder takes it
    do @(posedge clk); while (!byte_req.ready);
    bytes_sent++;
    predict_byte(b);
  endtask

  // Data byte biased toward the extremes and toward a stray header value
  function automatic logic [7:0] pick_data_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return HEADER_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send a complete frame with random content; prepend a zero byte when the
  // previous byte would not let the header open a frame
  task automatic send_frame(input bit good_footer);
    if (prev_byte != FOOTER_BYTE) send_byte(FOOTER_BYTE);
    send_byte(HEADER_BYTE);
    for (int i = 0; i < DATA_BYTES; i++) send_byte(pick_data_byte());
    send_byte(8'($urandom_range(0, 255)));                      // flag byte
    send_byte(good_footer ? FOOTER_BYTE : 8'($urandom_range(1, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random ready gaps, check on every accepted result
  // --------------------------------------------------------------------------
  initial begin : sink_ready
    int stall;
    chan_res.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = snk_idle ? $urandom_range(0, 3) : 0;
      repeat (stall) begin
        chan_res.ready <= 1'b0;
        @(posedge clk);
      end
      chan_res.ready <= 1'b1;
      do @(posedge clk); while (!chan_res.valid);
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  task automatic check_channel();
    result_t want;
    if (expected_channels.size() == 0) begin
      $error("channel result with nothing expected: index %0d value %0d",
             chan_res.channel_index, chan_res.channel_value);
      error_count++;
    end else begin
      want = expected_channels.pop_front();
      check_field("channel_index",   16'(want.channel_index),   16'(chan_res.channel_index));
      check_field("channel_value",   16'(want.channel_value),   16'(chan_res.channel_value));
      check_field("digital_ch17",    16'(want.digital_ch17),    16'(chan_res.digital_ch17));
      check_field("digital_ch18",    16'(want.digital_ch18),    16'(chan_res.digital_ch18));
      check_field("frame_lost",      16'(want.frame_lost),      16'(chan_res.frame_lost));
      check_field("failsafe_active", 16'(want.failsafe_active),
                  16'(chan_res.failsafe_active));
      check_field("last_of_frame",   16'(want.last_of_frame),   16'(chan_res.last_of_frame));
      results_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && chan_res.valid && chan_res.ready) check_channel();
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Extremes and the corner cases of framing
  task automatic test_directed();
    // header as the first byte after reset opens a frame
    send_byte(HEADER_BYTE);
    // all-ones channels 0..7, a header value inside the frame, zeros after
    for (int i = 1; i <= 11; i++) send_byte(8'hFF);
    send_byte(HEADER_BYTE);
    for (int i = 13; i <= DATA_BYTES; i++) send_byte(8'h00);
    send_byte(8'hFF);          // every flag set, upper nibble must be ignored
    send_byte(FOOTER_BYTE);
    // header right after a good footer opens the next frame
    send_byte(HEADER_BYTE);
    for (int i = 1; i <= DATA_BYTES; i++) send_byte(8'h00);
    send_byte(8'hF0);          // upper nibble only: flags all clear
    send_byte(8'h01);          // bad footer: drop the frame
    // header after a nonzero byte is ignored while hunting
    send_byte(HEADER_BYTE);
    send_byte(8'hAA);
    send_byte(HEADER_BYTE);
  endtask

  // Mostly well-formed frames, some with bad footers, noise in between
  task automatic test_random_frames();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 50) begin
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
      send_frame($urandom_range(0, 9) != 0);
    end
  endtask

  // Frames back to back with no gaps on either side
  task automatic test_back_to_back();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    repeat (3) send_frame(1'b1);
    src_idle = 1'b1;
    snk_idle = 1'b1;
  endtask

  // Full-rate bytes against a stalling sink, so the frame queue fills up
  task automatic test_output_backpressure();
    src_idle = 1'b0;
    repeat (5) send_frame(1'b1);
    src_idle = 1'b1;
  endtask

  // Raw byte noise, biased toward header and footer values
  task automatic test_noise();
    repeat (40) begin
      case ($urandom_range(0, 3))
        0:       send_byte(FOOTER_BYTE);
        1:       send_byte(HEADER_BYTE);
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    error_count     = 0;
    bytes_sent      = 0;
    results_checked = 0;
    frames_good     = 0;
    frames_dropped  = 0;
    src_idle        = 1'b1;
    snk_idle        = 1'b1;
    clear_frame_state();

    byte_req.valid   <= 1'b0;
    byte_req.rx_byte <= 8'h00;
    rst_n            <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_frames();
    test_back_to_back();
    test_output_backpressure();
    test_noise();
    test_random_frames();

    // drop valid once the last request is taken
    byte_req.valid <= 1'b0;

    // wait for every owed result, then let the pipeline settle
    while (expected_channels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d byte requests: %0d good frames, %0d dropped on a bad footer.",
             bytes_sent, frames_good, frames_dropped);
    $display("Checked %0d channel results under random and zero gaps on both sides.",
             results_checked);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
